[rtl/utf8_to_utf32_decoder_defines.svh]
// assertion macros shared by the decoder checker
// needs clk and rst_n in the scope where the macros are used
`ifndef UTF8_TO_UTF32_DECODER_DEFINES_SVH
`define UTF8_TO_UTF32_DECODER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define U8D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define U8D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/u8d_pkg.sv]
// types, codes and helpers of the utf-8 to utf-32 decoder
// no dependencies
package u8d_pkg;

  localparam int unsigned U8D_MID_DEPTH = 2;
  localparam int unsigned U8D_OUT_DEPTH = 2;

  localparam int unsigned CP_W   = 31;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_LEAD  = 2'd1,
    ERR_TRUNC = 2'd2
  } err_code_t;

  // classified byte handed from front to back
  // seq_len: 0 bad lead, 1 ascii, 2..6 lead of that length
  typedef struct packed {
    logic [BYTE_W-1:0] raw;
    logic [6:0]        data;
    logic [LEN_W-1:0]  seq_len;
    logic              eos;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    err_code_t       error_code;
    logic            last;
  } result_t;

  function automatic logic [LEN_W-1:0] seq_length(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] n;
    begin
      if (b[7] == 1'b0)              n = 3'd1;
      else if (b[7:6] == 2'b10)      n = 3'd0;
      else if (b[7:5] == 3'b110)     n = 3'd2;
      else if (b[7:4] == 4'b1110)    n = 3'd3;
      else if (b[7:3] == 5'b11110)   n = 3'd4;
      else if (b[7:2] == 6'b111110)  n = 3'd5;
      else if (b[7:1] == 7'b1111110) n = 3'd6;
      else                           n = 3'd0;
      return n;
    end
  endfunction

endpackage

[rtl/u8d_fifo.sv]
// small register queue with count, used between the decoder stages
// depends on nothing but its parameters (DEPTH >= 2)
module u8d_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[rtl/u8d_front.sv]
// front stage: classifies each raw byte and extracts its lead payload bits
// depends on u8d_pkg
module u8d_front
  import u8d_pkg::*;
(
  input  logic [BYTE_W-1:0] byte_in,
  input  logic              end_of_string,
  output item_t             item
);

  logic [LEN_W-1:0] len;
  logic [6:0]       mask;

  always_comb begin
    len = seq_length(byte_in);
    case (len)
      3'd1:    mask = 7'h7f;
      3'd2:    mask = 7'h1f;
      3'd3:    mask = 7'h0f;
      3'd4:    mask = 7'h07;
      3'd5:    mask = 7'h03;
      3'd6:    mask = 7'h01;
      default: mask = 7'h00;
    endcase
    item.raw     = byte_in;
    item.data    = byte_in[6:0] & mask;
    item.seq_len = len;
    item.eos     = end_of_string;
  end

endmodule

[rtl/u8d_back.sv]
// back stage: sequence state, value assembly and result generation
// depends on u8d_pkg
module u8d_back
  import u8d_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    item_valid,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  logic [CP_W-1:0]  pv_r, pv_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [CP_W-1:0]  shifted;
  logic [LEN_W-1:0] rem_dec;

  assign shifted = {pv_r[CP_W-7:0], item.raw[5:0]};
  assign rem_dec = rem_r - LEN_W'(1);

  always_comb begin
    pv_nxt         = pv_r;
    rem_nxt        = rem_r;
    res_valid      = 1'b0;
    res.code_point = '0;
    res.error_code = ERR_OK;
    res.last       = item.eos;
    if (item_valid) begin
      if (rem_r != '0) begin
        // continuation byte, taken whatever its top bits are
        pv_nxt  = shifted;
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          res_valid      = 1'b1;
          res.code_point = shifted;
          pv_nxt         = '0;
        end else if (item.eos) begin
          res_valid      = 1'b1;
          res.error_code = ERR_TRUNC;
          pv_nxt         = '0;
          rem_nxt        = '0;
        end
      end else if (item.seq_len == 3'd1) begin
        res_valid      = 1'b1;
        res.code_point = {{(CP_W-7){1'b0}}, item.data};
      end else if (item.seq_len == '0) begin
        res_valid      = 1'b1;
        res.error_code = ERR_LEAD;
        pv_nxt         = '0;
      end else if (item.eos) begin
        // lead byte at string end
        res_valid      = 1'b1;
        res.error_code = ERR_TRUNC;
        pv_nxt         = '0;
      end else begin
        pv_nxt  = {{(CP_W-7){1'b0}}, item.data};
        rem_nxt = item.seq_len - LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= '0;
      rem_r <= '0;
    end else begin
      pv_r  <= pv_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

[rtl/utf8_to_utf32_decoder.sv]
// UTF-8 to UTF-32 stream decoder, one byte per clock sustained while no
// queue is full. A byte is classified on entry and parked in a short
// queue; the back stage takes one queued byte per cycle whenever the
// result queue has room; results reach the out_ ports from that queue.
// Lead bytes 0xC0-0xFD open 2..6 byte sequences, continuation bytes are not
// checked, invalid lead bytes give error 1 and a sequence cut short by the
// end-of-string flag gives error 2 (code point zero in both cases).
// The rate is set by the back stage's combinational shift-and-or update.
// depends on u8d_pkg, u8d_front, u8d_back, u8d_fifo
module utf8_to_utf32_decoder
  import u8d_pkg::*;
#(
  parameter int unsigned MID_DEPTH = U8D_MID_DEPTH,
  parameter int unsigned OUT_DEPTH = U8D_OUT_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [BYTE_W-1:0] in_byte_in,
  input  logic              in_end_of_string,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [CP_W-1:0]   out_code_point,
  output logic [1:0]        out_error_code,
  output logic              out_last_result
);

  item_t   front_item;
  item_t   mid_item;
  logic    mid_empty;
  logic    out_q_full;
  logic    back_take;
  logic    res_valid;
  result_t res;
  result_t out_res;

  u8d_front u_front (
    .byte_in       (in_byte_in),
    .end_of_string (in_end_of_string),
    .item          (front_item)
  );

  u8d_fifo #(
    .WIDTH ($bits(item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_item),
    .full  (in_full),
    .pop   (back_take),
    .rdata (mid_item),
    .empty (mid_empty)
  );

  // at most one result per byte, so room for one is enough
  assign back_take = !mid_empty && !out_q_full;

  u8d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (back_take),
    .item       (mid_item),
    .res_valid  (res_valid),
    .res        (res)
  );

  u8d_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .wdata (res),
    .full  (out_q_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_code_point  = out_res.code_point;
  assign out_error_code  = out_res.error_code;
  assign out_last_result = out_res.last;

endmodule

[rtl/utf8_to_utf32_decoder_checker.sv]
// port-level checks of the decoder, bound to the top level
// depends on u8d_pkg and utf8_to_utf32_decoder_defines.svh
`include "utf8_to_utf32_decoder_defines.svh"

module utf8_to_utf32_decoder_checker
  import u8d_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_empty,
  input logic              out_pop,
  input logic [CP_W-1:0]   out_code_point,
  input logic [1:0]        out_error_code,
  input logic              out_last_result
);

  `U8D_ASSERT_NOW(a_err_known, !out_empty,
    out_error_code == ERR_OK || out_error_code == ERR_LEAD || out_error_code == ERR_TRUNC,
    "unknown error code on result")

  `U8D_ASSERT_NOW(a_err_zero_cp, !out_empty && out_error_code != ERR_OK,
    out_code_point == '0, "error result carries a nonzero code point")

  `U8D_ASSERT_NOW(a_trunc_last, !out_empty && out_error_code == ERR_TRUNC,
    out_last_result, "truncation reported on a byte that is not the last")

  `U8D_ASSERT_NEXT(a_res_hold, !out_empty && !out_pop,
    !out_empty && $stable(out_code_point) && $stable(out_error_code),
    "waiting transaction changed before it was taken")

endmodule

bind utf8_to_utf32_decoder utf8_to_utf32_decoder_checker u_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_empty       (out_empty),
  .out_pop         (out_pop),
  .out_code_point  (out_code_point),
  .out_error_code  (out_error_code),
  .out_last_result (out_last_result)
);
